// ===== design/ikin_pkg.sv =====
package ikin_pkg;

  // Field widths of the target point, the link lengths and the joint angles.
  localparam int COORD_W = 16;
  localparam int LEN_W   = 15;
  localparam int ANG_W   = 16;

  // Angle format of the results and the internal Q30 angle scale.
  localparam int ANGLE_FRACTION_BITS = 12;
  localparam int Q_ANG               = 30;
  localparam int FIELD_SHIFT         = Q_ANG - ANGLE_FRACTION_BITS;

  // CORDIC datapath: vector width, angle accumulator width, step count.
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int COR_W        = 34;
  localparam int COR_ANG_W    = 34;
  localparam int COR_LAT      = CORDIC_STEPS + 1;
  localparam int NORM_BIT     = 28;
  localparam int SH_W         = 5;

  // Digit-by-digit square root: radicand width and one root bit per stage.
  localparam int SQ_IN_W   = 62;
  localparam int SQ_STEPS  = SQ_IN_W / 2;
  localparam int SQ_ROOT_W = SQ_STEPS;
  localparam int SQ_REM_W  = SQ_ROOT_W + 3;
  localparam int SQ_LAT    = SQ_STEPS;

  // Width of the final angle sums before rounding.
  localparam int ACC_W = 36;

  localparam logic signed [COR_ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ACC_W-1:0]     PI_Q30      = 36'sd3373259426;

  // Arctangent of 2^-i in Q30, rounded.
  localparam logic signed [COR_ANG_W-1:0] ATAN_Q30 [TAB_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_UPPER_LINK = 2'd0;
  localparam logic [CFG_ADDR_W-3:0] REG_LOWER_LINK = 2'd1;
  localparam logic [CFG_ADDR_W-3:0] REG_WRIST      = 2'd2;

  // Link geometry handed from the register file to the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]     upper_link;
    logic [LEN_W-1:0]     wrist;
    logic [2*LEN_W-1:0]   upper_sq;
    logic [2*LEN_W-1:0]   lower_sq;
    logic [2*LEN_W:0]     den_links;
  } ikin_cfg_t;

endpackage

// ===== design/ikin_if.sv =====
// Target point channel.
interface ikin_in_if import ikin_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic signed [COORD_W-1:0] target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

// Joint angle channel.
interface ikin_out_if import ikin_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] base_angle;
  logic signed [ANG_W-1:0] shoulder_angle;
  logic signed [ANG_W-1:0] elbow_angle;
  logic                    reachable;

  modport source (output valid, output base_angle, output shoulder_angle,
                  output elbow_angle, output reachable, input ready);
  modport sink   (input valid, input base_angle, input shoulder_angle,
                  input elbow_angle, input reachable, output ready);
endinterface

// ===== design/ikin_isqrt.sv =====
module ikin_isqrt import ikin_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [SQ_IN_W-1:0]   rad_i,
  output logic [SQ_ROOT_W-1:0] root_o
);

  logic [SQ_REM_W-1:0]  rem_r  [SQ_STEPS-1];
  logic [SQ_IN_W-1:0]   rad_r  [SQ_STEPS-1];
  logic [SQ_ROOT_W-1:0] root_r [SQ_STEPS];

  // One root bit per stage, two radicand bits brought down each time.
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic [SQ_REM_W-1:0]  rem_in;
    logic [SQ_REM_W-1:0]  rem_sh;
    logic [SQ_REM_W-1:0]  trial;
    logic [SQ_ROOT_W-1:0] root_in;
    logic [SQ_IN_W-1:0]   rad_in;
    logic                 fits;

    if (i == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_tail
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    assign rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[i] <= {root_in[SQ_ROOT_W-2:0], fits};
      end
    end

    // The remainder and radicand are not needed after the last bit.
    if (i < SQ_STEPS - 1) begin : g_carry
      logic [SQ_REM_W-1:0] rem_nxt;
      assign rem_nxt = fits ? (rem_sh - trial) : rem_sh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          rad_r[i] <= {rad_in[SQ_IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_r[SQ_STEPS-1];

endmodule

// ===== design/ikin_cordic.sv =====
module ikin_cordic import ikin_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COR_W-1:0]     im_i,
  input  logic signed [COR_W-1:0]     re_i,
  output logic signed [COR_ANG_W-1:0] ang_o
);

  logic signed [COR_W-1:0]     re_r   [CORDIC_STEPS];
  logic signed [COR_W-1:0]     im_r   [CORDIC_STEPS];
  logic signed [COR_ANG_W-1:0] ang_r  [CORDIC_STEPS+1];
  logic                        zero_r [CORDIC_STEPS+1];

  logic [COR_W-1:0]            re_abs;
  logic [COR_W-1:0]            im_abs;
  logic [COR_W-1:0]            mag;
  logic [SH_W-1:0]             pos;
  logic [SH_W-1:0]             sh;
  logic signed [COR_W-1:0]     re_s;
  logic signed [COR_W-1:0]     im_s;
  logic signed [COR_W-1:0]     re_q;
  logic signed [COR_W-1:0]     im_q;
  logic signed [COR_ANG_W-1:0] ang_q;

  // Scale up to full range, then fold the left half plane onto the right.
  always_comb begin
    re_abs = re_i[COR_W-1] ? -re_i : re_i;
    im_abs = im_i[COR_W-1] ? -im_i : im_i;
    mag    = re_abs | im_abs;
    pos    = '0;
    for (int b = 0; b < NORM_BIT; b++) begin
      if (mag[b]) pos = SH_W'(b);
    end
    sh    = (|mag[COR_W-1:NORM_BIT]) ? '0 : (SH_W'(NORM_BIT) - pos);
    re_s  = re_i <<< sh;
    im_s  = im_i <<< sh;
    re_q  = re_s;
    im_q  = im_s;
    ang_q = '0;
    if (re_s[COR_W-1]) begin
      if (!im_s[COR_W-1]) begin
        re_q  = im_s;
        im_q  = -re_s;
        ang_q = HALF_PI_Q30;
      end else begin
        re_q  = -im_s;
        im_q  = re_s;
        ang_q = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r[0]   <= re_q;
      im_r[0]   <= im_q;
      ang_r[0]  <= ang_q;
      zero_r[0] <= (mag == '0);
    end
  end

  // Vectoring micro-rotations, one per stage.
  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        ang_r[j+1]  <= im_r[j][COR_W-1] ? (ang_r[j] - ATAN_Q30[j])
                                        : (ang_r[j] + ATAN_Q30[j]);
        zero_r[j+1] <= zero_r[j];
      end
    end

    if (j < CORDIC_STEPS - 1) begin : g_vec
      logic signed [COR_W-1:0] dx;
      logic signed [COR_W-1:0] dy;
      assign dx = im_r[j] >>> j;
      assign dy = re_r[j] >>> j;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!im_r[j][COR_W-1]) begin
            re_r[j+1] <= re_r[j] + dx;
            im_r[j+1] <= im_r[j] - dy;
          end else begin
            re_r[j+1] <= re_r[j] - dx;
            im_r[j+1] <= im_r[j] + dy;
          end
        end
      end
    end
  end

  // A zero vector has angle zero.
  assign ang_o = zero_r[CORDIC_STEPS] ? '0 : ang_r[CORDIC_STEPS];

endmodule

// ===== design/ikin_cfg.sv =====
module ikin_cfg import ikin_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output ikin_cfg_t             cfg_o
);

  logic [LEN_W-1:0]   upper_r;
  logic [LEN_W-1:0]   lower_r;
  logic [LEN_W-1:0]   wrist_r;
  logic [2*LEN_W-1:0] upper_sq_r;
  logic [2*LEN_W-1:0] lower_sq_r;
  logic [2*LEN_W-1:0] links_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= '0;
      lower_r <= '0;
      wrist_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[CFG_ADDR_W-1:2])
        REG_UPPER_LINK: upper_r <= pwdata[LEN_W-1:0];
        REG_LOWER_LINK: lower_r <= pwdata[LEN_W-1:0];
        REG_WRIST:      wrist_r <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[CFG_ADDR_W-1:2])
      REG_UPPER_LINK: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, upper_r};
      REG_LOWER_LINK: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, lower_r};
      REG_WRIST:      prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, wrist_r};
      default:        prdata = '0;
    endcase
  end

  // Products of the link lengths, refreshed every cycle.
  always_ff @(posedge clk) begin
    upper_sq_r <= upper_r * upper_r;
    lower_sq_r <= lower_r * lower_r;
    links_r    <= upper_r * lower_r;
  end

  assign cfg_o.upper_link = upper_r;
  assign cfg_o.wrist      = wrist_r;
  assign cfg_o.upper_sq   = upper_sq_r;
  assign cfg_o.lower_sq   = lower_sq_r;
  assign cfg_o.den_links  = {links_r, 1'b0};

endmodule

// ===== design/three_joint_arm_inverse_kinematics_top.sv =====
// Inverse kinematics for a three-joint arm. Each target point (x, y, z) in
// signed Q11.4 gives base, shoulder and elbow angles in signed Q3.12 radians
// and a reachable flag; an unreachable point returns zero angles. The block
// is a 125-stage pipeline: a new point is taken every cycle unless the output
// is stalled, and a stalled output holds the whole pipeline. The depth is set
// by three digit-by-digit square roots of 31 stages each, one 17-stage CORDIC
// vectoring and the stages of squaring, law-of-cosines and output arithmetic.
// Link lengths and the wrist offset sit at byte addresses 0, 4 and 8 of the
// APB port and must be written while no point is in flight.
module three_joint_arm_inverse_kinematics_top import ikin_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ikin_in_if.sink               in_ch,
  ikin_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Stage numbers, counted from the input register.
  localparam int P_SUM1  = 2;
  localparam int P_R     = P_SUM1 + SQ_LAT;
  localparam int P_RH    = P_R + 1;
  localparam int P_RH2   = P_RH + 1;
  localparam int P_SUM2  = P_RH2 + 1;
  localparam int P_BIGR  = P_SUM2 + SQ_LAT;
  localparam int P_PROD1 = P_BIGR + 1;
  localparam int P_LAW   = P_PROD1 + 1;
  localparam int P_CHK   = P_LAW + 1;
  localparam int P_NORM  = P_CHK + 1;
  localparam int P_AB    = P_NORM + 1;
  localparam int P_PROD2 = P_AB + 1;
  localparam int P_S     = P_PROD2 + SQ_LAT;
  localparam int P_ACOS  = P_S + COR_LAT;
  localparam int P_BASE  = COR_LAT;
  localparam int P_ELEV  = P_RH + COR_LAT;
  localparam int P_OUT   = P_ACOS + 3;

  localparam int D_Z    = P_RH;
  localparam int D_ZZ   = P_RH2 - 1;
  localparam int D_BASE = P_ACOS - P_BASE;
  localparam int D_ELEV = P_ACOS - P_ELEV;
  localparam int D_OK   = P_ACOS - P_CHK;
  localparam int D_N    = P_S - P_NORM;

  localparam logic signed [ACC_W-1:0] FIELD_MAX = ACC_W'(2**(ANG_W-1) - 1);
  localparam logic signed [ACC_W-1:0] FIELD_MIN = -FIELD_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FIELD_SHIFT - 1);

  typedef struct packed {
    logic [29:0]        d;
    logic signed [30:0] n;
  } ratio_t;

  // Scale d into [2^29, 2^30), truncating n toward zero on the way down.
  function automatic ratio_t norm_ratio(input logic [31:0] d,
                                        input logic signed [34:0] n,
                                        input logic [4:0] pos);
    ratio_t             res;
    logic [34:0]        mag;
    logic [34:0]        mag_s;
    logic [34:0]        d_s;
    logic signed [34:0] n_s;
    logic [4:0]         sh;
    mag = n[34] ? -n : n;
    if (pos >= 5'd30) begin
      sh    = pos - 5'd29;
      d_s   = {3'b000, d} >> sh;
      mag_s = mag >> sh;
      n_s   = n[34] ? -$signed(mag_s) : $signed(mag_s);
    end else begin
      sh  = 5'd29 - pos;
      d_s = {3'b000, d} << sh;
      n_s = n <<< sh;
    end
    res.d = d_s[29:0];
    res.n = n_s[30:0];
    return res;
  endfunction

  // Round half up from Q30 and saturate to the field.
  function automatic logic signed [ANG_W-1:0] to_field(input logic signed [ACC_W-1:0] q);
    logic signed [ACC_W-1:0] v;
    v = (q + ROUND_HALF) >>> FIELD_SHIFT;
    if (v > FIELD_MAX) v = FIELD_MAX;
    if (v < FIELD_MIN) v = FIELD_MIN;
    return v[ANG_W-1:0];
  endfunction

  ikin_cfg_t cfg;
  logic      adv;
  logic      vld_r [P_OUT+1];

  // Input stage.
  logic signed [COORD_W-1:0] x0_r, y0_r, z0_r;
  // Squares and horizontal radius.
  logic signed [31:0]        xsq, ysq, zsq;
  logic [30:0]               xx1_r, yy1_r, zz1_r;
  logic [31:0]               sum1_r;
  logic [SQ_ROOT_W-1:0]      r_root;
  logic signed [16:0]        rh_r;
  logic signed [33:0]        rhsq;
  logic [31:0]               rh2_r;
  logic [31:0]               sum2_r;
  logic [SQ_ROOT_W-1:0]      bigr_root;
  // Law of cosines.
  logic [31:0]               r2_r;
  logic [30:0]               l1r_r;
  logic [31:0]               d1_r;
  logic signed [34:0]        n1_r, n2_r;
  logic [34:0]               mag1, mag2;
  logic [4:0]                pos1, pos2;
  logic                      ok_nxt;
  logic                      ok_r;
  logic [31:0]               d1c_r, d2c_r;
  logic signed [34:0]        n1c_r, n2c_r;
  logic [4:0]                pos1_r, pos2_r;
  ratio_t                    q1_r, q2_r;
  logic signed [32:0]        a1, b1, a2, b2;
  logic [30:0]               a1_r, b1_r, a2_r, b2_r;
  logic [SQ_IN_W-1:0]        pr1_r, pr2_r;
  logic [SQ_ROOT_W-1:0]      s1_root, s2_root;
  // Angles.
  logic signed [COR_ANG_W-1:0] base_ang, elev_ang, b_ang, c_ang;
  logic signed [ACC_W-1:0]     sh_r, cpi_r, base2_r;
  logic                        ok2_r;
  logic signed [ACC_W-1:0]     el_r, sh3_r, base3_r;
  logic                        ok3_r;
  logic signed [ANG_W-1:0]     base_out_r, sh_out_r, el_out_r;
  logic                        reach_out_r;

  // Delay lines.
  logic signed [COORD_W-1:0]   z_d_r    [D_Z];
  logic [30:0]                 zz_d_r   [D_ZZ];
  logic signed [COR_ANG_W-1:0] base_d_r [D_BASE];
  logic signed [COR_ANG_W-1:0] elev_d_r [D_ELEV];
  logic                        ok_d_r   [D_OK];
  logic signed [30:0]          n1_d_r   [D_N];
  logic signed [30:0]          n2_d_r   [D_N];

  ikin_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The pipeline moves whenever the output register is free or being taken.
  assign adv         = !vld_r[P_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= P_OUT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i <= P_OUT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Horizontal radius r = sqrt(x^2 + y^2), base angle atan2(x, y).
  assign xsq = x0_r * x0_r;
  assign ysq = y0_r * y0_r;
  assign zsq = z0_r * z0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r   <= in_ch.target_x;
      y0_r   <= in_ch.target_y;
      z0_r   <= in_ch.target_z;
      xx1_r  <= xsq[30:0];
      yy1_r  <= ysq[30:0];
      zz1_r  <= zsq[30:0];
      sum1_r <= {1'b0, xx1_r} + {1'b0, yy1_r};
    end
  end

  ikin_cordic u_base (
    .clk   (clk),
    .en    (adv),
    .im_i  (COR_W'(x0_r)),
    .re_i  (COR_W'(y0_r)),
    .ang_o (base_ang)
  );

  ikin_isqrt u_sqrt_r (
    .clk    (clk),
    .en     (adv),
    .rad_i  ({{(SQ_IN_W-32){1'b0}}, sum1_r}),
    .root_o (r_root)
  );

  // Offset radius and the distance R to the wrist point.
  assign rhsq = rh_r * rh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rh_r   <= $signed({1'b0, r_root[15:0]}) - $signed({2'b00, cfg.wrist});
      rh2_r  <= rhsq[31:0];
      sum2_r <= rh2_r + {1'b0, zz_d_r[D_ZZ-1]};
    end
  end

  ikin_cordic u_elev (
    .clk   (clk),
    .en    (adv),
    .im_i  (COR_W'(z_d_r[D_Z-1])),
    .re_i  (COR_W'(rh_r)),
    .ang_o (elev_ang)
  );

  ikin_isqrt u_sqrt_bigr (
    .clk    (clk),
    .en     (adv),
    .rad_i  ({{(SQ_IN_W-32){1'b0}}, sum2_r}),
    .root_o (bigr_root)
  );

  // Numerators and denominators of both cosine ratios.
  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r  <= bigr_root[15:0] * bigr_root[15:0];
      l1r_r <= cfg.upper_link * bigr_root[15:0];
      d1_r  <= {l1r_r, 1'b0};
      n1_r  <= $signed({5'd0, cfg.upper_sq}) + $signed({3'd0, r2_r})
             - $signed({5'd0, cfg.lower_sq});
      n2_r  <= $signed({5'd0, cfg.upper_sq}) + $signed({5'd0, cfg.lower_sq})
             - $signed({3'd0, r2_r});
    end
  end

  // Range check and leading-one position of each denominator.
  always_comb begin
    mag1 = n1_r[34] ? -n1_r : n1_r;
    mag2 = n2_r[34] ? -n2_r : n2_r;
    ok_nxt = (d1_r != '0) && (mag1 <= {3'b000, d1_r})
          && (cfg.den_links != '0) && (mag2 <= {4'b0000, cfg.den_links});
    pos1 = '0;
    pos2 = '0;
    for (int b = 0; b < 32; b++) begin
      if (d1_r[b]) pos1 = 5'(b);
      if (b < 2*LEN_W+1 && cfg.den_links[b[4:0]]) pos2 = 5'(b);
    end
  end

  assign a1 = $signed({3'b000, q1_r.d}) - 33'(q1_r.n);
  assign b1 = $signed({3'b000, q1_r.d}) + 33'(q1_r.n);
  assign a2 = $signed({3'b000, q2_r.d}) - 33'(q2_r.n);
  assign b2 = $signed({3'b000, q2_r.d}) + 33'(q2_r.n);

  // acos(n / d) is taken as atan2(sqrt((d - n)(d + n)), n).
  always_ff @(posedge clk) begin
    if (adv) begin
      ok_r   <= ok_nxt;
      d1c_r  <= d1_r;
      d2c_r  <= {1'b0, cfg.den_links};
      n1c_r  <= n1_r;
      n2c_r  <= n2_r;
      pos1_r <= pos1;
      pos2_r <= pos2;
      q1_r   <= norm_ratio(d1c_r, n1c_r, pos1_r);
      q2_r   <= norm_ratio(d2c_r, n2c_r, pos2_r);
      a1_r   <= a1[30:0];
      b1_r   <= b1[30:0];
      a2_r   <= a2[30:0];
      b2_r   <= b2[30:0];
      pr1_r  <= a1_r * b1_r;
      pr2_r  <= a2_r * b2_r;
    end
  end

  ikin_isqrt u_sqrt_s1 (
    .clk    (clk),
    .en     (adv),
    .rad_i  (pr1_r),
    .root_o (s1_root)
  );

  ikin_isqrt u_sqrt_s2 (
    .clk    (clk),
    .en     (adv),
    .rad_i  (pr2_r),
    .root_o (s2_root)
  );

  ikin_cordic u_acos_b (
    .clk   (clk),
    .en    (adv),
    .im_i  ($signed({3'b000, s1_root})),
    .re_i  (COR_W'(n1_d_r[D_N-1])),
    .ang_o (b_ang)
  );

  ikin_cordic u_acos_c (
    .clk   (clk),
    .en    (adv),
    .im_i  ($signed({3'b000, s2_root})),
    .re_i  (COR_W'(n2_d_r[D_N-1])),
    .ang_o (c_ang)
  );

  // Side values that wait for the slower paths.
  always_ff @(posedge clk) begin
    if (adv) begin
      z_d_r[0]    <= z0_r;
      zz_d_r[0]   <= zz1_r;
      base_d_r[0] <= base_ang;
      elev_d_r[0] <= elev_ang;
      ok_d_r[0]   <= ok_r;
      n1_d_r[0]   <= q1_r.n;
      n2_d_r[0]   <= q2_r.n;
      for (int i = 1; i < D_Z; i++)    z_d_r[i]    <= z_d_r[i-1];
      for (int i = 1; i < D_ZZ; i++)   zz_d_r[i]   <= zz_d_r[i-1];
      for (int i = 1; i < D_BASE; i++) base_d_r[i] <= base_d_r[i-1];
      for (int i = 1; i < D_ELEV; i++) elev_d_r[i] <= elev_d_r[i-1];
      for (int i = 1; i < D_OK; i++)   ok_d_r[i]   <= ok_d_r[i-1];
      for (int i = 1; i < D_N; i++) begin
        n1_d_r[i] <= n1_d_r[i-1];
        n2_d_r[i] <= n2_d_r[i-1];
      end
    end
  end

  // Shoulder = elevation + B, elbow = C + shoulder - pi, then the fields.
  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r        <= ACC_W'(elev_d_r[D_ELEV-1]) + ACC_W'(b_ang);
      cpi_r       <= ACC_W'(c_ang) - PI_Q30;
      base2_r     <= ACC_W'(base_d_r[D_BASE-1]);
      ok2_r       <= ok_d_r[D_OK-1];
      el_r        <= cpi_r + sh_r;
      sh3_r       <= sh_r;
      base3_r     <= base2_r;
      ok3_r       <= ok2_r;
      base_out_r  <= ok3_r ? to_field(base3_r) : '0;
      sh_out_r    <= ok3_r ? to_field(sh3_r) : '0;
      el_out_r    <= ok3_r ? to_field(el_r) : '0;
      reach_out_r <= ok3_r;
    end
  end

  assign out_ch.valid          = vld_r[P_OUT];
  assign out_ch.base_angle     = base_out_r;
  assign out_ch.shoulder_angle = sh_out_r;
  assign out_ch.elbow_angle    = el_out_r;
  assign out_ch.reachable      = reach_out_r;

endmodule
